[src/csgl_pkg.sv]
// ----------------------------------------------------------------------------
// csgl_pkg: shared types and constants for the segment glyph lookup
// Holds the sequencer state type, the shared adder operations, the request
// and status codes, and the fixed field widths of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package csgl_pkg;

	localparam int MEM_WORDS_DEF = 8192;

	// Field widths fixed by the interface.
	localparam int SEG_W   = 11;
	localparam int WADDR_W = 13;
	localparam int WORD_W  = 16;
	localparam int CODE_W  = 21;
	localparam int STAT_W  = 2;

	// Shared adder width: wide enough for a character code and for every
	// table address the lookup can form (below 2^17).
	localparam int ALU_W = 22;

	localparam logic [WORD_W-1:0] LAST_CODE = 16'hFFFF;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [STAT_W-1:0] ST_MAPPED = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_SEG = 2'd1;
	localparam logic [STAT_W-1:0] ST_BELOW  = 2'd2;
	localparam logic [STAT_W-1:0] ST_OOB    = 2'd3;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_INC,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_START,
		S_RD_START,
		S_RD_DELTA,
		S_RD_RANGE,
		S_CHECK,
		S_DIRECT,
		S_GA_OFS,
		S_GA_IDX,
		S_RD_GLYPH,
		S_GLYPH,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[src/csgl_ram.sv]
// ----------------------------------------------------------------------------
// csgl_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module csgl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/csgl_alu.sv]
// ----------------------------------------------------------------------------
// csgl_alu: shared adder of the lookup sequencer
// Adds, adds with increment, or subtracts; the carry out of a subtraction
// is set when a is not below b.
// ----------------------------------------------------------------------------
`default_nettype none

module csgl_alu (
	input  wire [csgl_pkg::ALU_W-1:0] a,
	input  wire [csgl_pkg::ALU_W-1:0] b,
	input  csgl_pkg::alu_op_t         op,
	output logic [csgl_pkg::ALU_W-1:0] y,
	output logic                       cout
);

	import csgl_pkg::*;

	logic [ALU_W-1:0] b_x;
	logic             cin;
	logic [ALU_W:0]   sum;

	always_comb begin
		case (op)
			ALU_ADD: begin
				b_x = b;
				cin = 1'b0;
			end
			ALU_INC: begin
				b_x = b;
				cin = 1'b1;
			end
			ALU_SUB: begin
				b_x = ~b;
				cin = 1'b1;
			end
			default: begin
				b_x = b;
				cin = 1'b0;
			end
		endcase
	end

	assign sum  = {1'b0, a} + {1'b0, b_x} + (ALU_W + 1)'(cin);
	assign y    = sum[ALU_W-1:0];
	assign cout = sum[ALU_W];

endmodule

`default_nettype wire

[src/cmap_segment_glyph_lookup.sv]
// A table write yields no result; the next item can follow at once.
// The scan reads one end code a cycle through the single RAM port and one shared adder;
// one lookup is in flight at a time. Reset clears the sequencer and the output valid and
// sets segment_count to 1; the table holds no defined value until written.
// ----------------------------------------------------------------------------
// cmap_segment_glyph_lookup: segment-mapping character to glyph lookup
// A word memory holds one segment-mapping character table that software fills
// by write items. A lookup item scans the end codes, fetches the segment start,
// delta and range offset, and maps the code directly or through the glyph array.
// ----------------------------------------------------------------------------
`default_nettype none

module cmap_segment_glyph_lookup #(
	parameter int MEM_WORDS = csgl_pkg::MEM_WORDS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,

	// Configuration: segment count of the loaded table.
	input  wire                         cfg_we,
	input  wire [csgl_pkg::SEG_W-1:0]   cfg_wdata,

	// Input items.
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [55:0]                  s_tdata,  // word_address[12:0], word_value[28:13],
	                                              // char_code[49:29], zero fill [55:50]
	input  wire                         s_tuser,  // func: 0 table write, 1 lookup

	// Result items.
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [23:0]                 m_tdata   // glyph_id[15:0], status[17:16],
	                                              // zero fill [23:18]
);

	import csgl_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [ALU_W-1:0] MEM_LIMIT = ALU_W'(MEM_WORDS);

	// Unpacked input fields.
	logic [WADDR_W-1:0] in_word_address;
	logic [WORD_W-1:0]  in_word_value;
	logic [CODE_W-1:0]  in_char_code;

	assign in_word_address = s_tdata[12:0];
	assign in_word_value   = s_tdata[28:13];
	assign in_char_code    = s_tdata[49:29];

	// Configuration register.
	logic [SEG_W-1:0] seg_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q <= SEG_W'(1);
		end else if (cfg_we) begin
			seg_cnt_q <= cfg_wdata;
		end
	end

	// Sequencer state and working registers.
	state_t state_q, state_d;

	logic [CODE_W-1:0] code_q, code_d;
	logic [SEG_W-1:0]  n_q, n_d;          // next end-code index to read
	logic [SEG_W-1:0]  chk_q, chk_d;      // index whose end code is in the RAM output
	logic              chk_valid_q, chk_valid_d;
	logic [ALU_W-1:0]  addr_q, addr_d;
	logic [WORD_W-1:0] start_q, start_d;
	logic [WORD_W-1:0] delta_q, delta_d;
	logic [WORD_W-1:0] range_q, range_d;
	logic [WORD_W-1:0] diff_q, diff_d;
	logic [WORD_W-1:0] res_glyph_q, res_glyph_d;
	logic [STAT_W-1:0] res_status_q, res_status_d;

	// Output register.
	logic              m_tvalid_q;
	logic [WORD_W-1:0] m_glyph_q;
	logic [STAT_W-1:0] m_status_q;
	logic              out_load;

	// Table RAM.
	logic              ram_we;
	logic [ALU_W-1:0]  ram_addr_w;
	logic [WORD_W-1:0] ram_rdata;

	// Shared adder.
	logic [ALU_W-1:0] alu_a, alu_b, alu_y;
	alu_op_t          alu_op;
	logic             alu_cout;

	csgl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr_w[AW-1:0]),
		.wdata (in_word_value),
		.rdata (ram_rdata)
	);

	csgl_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.op   (alu_op),
		.y    (alu_y),
		.cout (alu_cout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chk_valid_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			chk_valid_q <= chk_valid_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		code_q       <= code_d;
		n_q          <= n_d;
		chk_q        <= chk_d;
		addr_q       <= addr_d;
		start_q      <= start_d;
		delta_q      <= delta_d;
		range_q      <= range_d;
		diff_q       <= diff_d;
		res_glyph_q  <= res_glyph_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			m_glyph_q  <= res_glyph_q;
			m_status_q <= res_status_q;
		end
	end

	// Next state, RAM port and adder operand selection.
	always_comb begin
		state_d      = state_q;
		code_d       = code_q;
		n_d          = n_q;
		chk_d        = chk_q;
		chk_valid_d  = chk_valid_q;
		addr_d       = addr_q;
		start_d      = start_q;
		delta_d      = delta_q;
		range_d      = range_q;
		diff_d       = diff_q;
		res_glyph_d  = res_glyph_q;
		res_status_d = res_status_q;
		ram_we       = 1'b0;
		ram_addr_w   = addr_q;
		alu_a        = '0;
		alu_b        = '0;
		alu_op       = ALU_ADD;
		s_tready     = 1'b0;
		out_load     = 1'b0;

		case (state_q)
			S_IDLE: begin
				s_tready   = 1'b1;
				ram_addr_w = ALU_W'(in_word_address);
				if (s_tvalid) begin
					if (s_tuser == FUNC_WRITE) begin
						// Writes beyond the memory are dropped.
						ram_we = (ram_addr_w < MEM_LIMIT);
					end else begin
						code_d      = in_char_code;
						n_d         = '0;
						chk_valid_d = 1'b0;
						state_d     = S_SCAN;
					end
				end
			end

			S_SCAN: begin
				// End code minus character code: carry set when the segment covers it.
				alu_a      = ALU_W'(ram_rdata);
				alu_b      = ALU_W'(code_q);
				alu_op     = ALU_SUB;
				ram_addr_w = ALU_W'(n_q);
				if (chk_valid_q && (ram_rdata == LAST_CODE)) begin
					res_glyph_d  = '0;
					res_status_d = ST_NO_SEG;
					state_d      = S_DONE;
				end else if (chk_valid_q && alu_cout) begin
					state_d = S_START;
				end else if (n_q == seg_cnt_q) begin
					res_glyph_d  = '0;
					res_status_d = ST_NO_SEG;
					state_d      = S_DONE;
				end else if (ALU_W'(n_q) >= MEM_LIMIT) begin
					res_glyph_d  = '0;
					res_status_d = ST_OOB;
					state_d      = S_DONE;
				end else begin
					chk_valid_d = 1'b1;
					chk_d       = n_q;
					n_d         = n_q + SEG_W'(1);
				end
			end

			S_START: begin
				// Start code address: segment count + 1 + segment index.
				alu_a   = ALU_W'(seg_cnt_q);
				alu_b   = ALU_W'(chk_q);
				alu_op  = ALU_INC;
				addr_d  = alu_y;
				state_d = S_RD_START;
			end

			S_RD_START: begin
				alu_a  = addr_q;
				alu_b  = ALU_W'(seg_cnt_q);
				addr_d = alu_y;
				if (addr_q >= MEM_LIMIT) begin
					res_glyph_d  = '0;
					res_status_d = ST_OOB;
					state_d      = S_DONE;
				end else begin
					state_d = S_RD_DELTA;
				end
			end

			S_RD_DELTA: begin
				start_d = ram_rdata;
				alu_a   = addr_q;
				alu_b   = ALU_W'(seg_cnt_q);
				addr_d  = alu_y;
				if (addr_q >= MEM_LIMIT) begin
					res_glyph_d  = '0;
					res_status_d = ST_OOB;
					state_d      = S_DONE;
				end else begin
					state_d = S_RD_RANGE;
				end
			end

			S_RD_RANGE: begin
				// addr_q now holds the range offset address and keeps it.
				delta_d = ram_rdata;
				if (addr_q >= MEM_LIMIT) begin
					res_glyph_d  = '0;
					res_status_d = ST_OOB;
					state_d      = S_DONE;
				end else begin
					state_d = S_CHECK;
				end
			end

			S_CHECK: begin
				range_d = ram_rdata;
				alu_a   = ALU_W'(code_q);
				alu_b   = ALU_W'(start_q);
				alu_op  = ALU_SUB;
				diff_d  = alu_y[WORD_W-1:0];
				if (!alu_cout) begin
					res_glyph_d  = '0;
					res_status_d = ST_BELOW;
					state_d      = S_DONE;
				end else if (ram_rdata == '0) begin
					state_d = S_DIRECT;
				end else begin
					state_d = S_GA_OFS;
				end
			end

			S_DIRECT: begin
				alu_a        = ALU_W'(code_q);
				alu_b        = ALU_W'(delta_q);
				res_glyph_d  = alu_y[WORD_W-1:0];
				res_status_d = ST_MAPPED;
				state_d      = S_DONE;
			end

			S_GA_OFS: begin
				// The range offset counts bytes; its low bit is dropped.
				alu_a   = addr_q;
				alu_b   = ALU_W'(range_q[WORD_W-1:1]);
				addr_d  = alu_y;
				state_d = S_GA_IDX;
			end

			S_GA_IDX: begin
				alu_a   = addr_q;
				alu_b   = ALU_W'(diff_q);
				addr_d  = alu_y;
				state_d = S_RD_GLYPH;
			end

			S_RD_GLYPH: begin
				if (addr_q >= MEM_LIMIT) begin
					res_glyph_d  = '0;
					res_status_d = ST_OOB;
					state_d      = S_DONE;
				end else begin
					state_d = S_GLYPH;
				end
			end

			S_GLYPH: begin
				// A zero array entry means unmapped and is not offset by delta.
				alu_a        = ALU_W'(ram_rdata);
				alu_b        = ALU_W'(delta_q);
				res_glyph_d  = (ram_rdata == '0) ? '0 : alu_y[WORD_W-1:0];
				res_status_d = ST_MAPPED;
				state_d      = S_DONE;
			end

			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_status_q, m_glyph_q};

	// Every status other than mapped carries glyph zero.
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> ((m_status_q == ST_MAPPED) || (m_glyph_q == '0)))
		else $error("unmapped result with nonzero glyph");

	// The end code in the RAM output always belongs to the index just before the next one.
	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && chk_valid_q) |-> ((chk_q + SEG_W'(1)) == n_q))
		else $error("scan index out of step with RAM read");

	// A new result only appears when the sequencer leaves its done state.
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> ((state_q == S_DONE) && (state_d == S_IDLE)))
		else $error("result loaded outside done state");

	// Table writes only happen while idle.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_IDLE) && s_tvalid && (s_tuser == FUNC_WRITE)))
		else $error("table write outside an accepted write item");

endmodule

`default_nettype wire
